/* src/gmti_pkg.sv */
// Shared constants for the grid mesh triangle indexer.
`default_nettype none
package gmti_pkg;
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;
    localparam int HEIGHT_W = 32;
    localparam int IDX_W = 20;
    localparam int CFG_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int MIN_SIZE = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK = 2'd2;

    localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
    localparam logic [22:0] MAN_ZERO = 23'd0;
endpackage
`default_nettype wire

/* src/gmti_ram.sv */
// Generic single-address RAM with read-before-write and a registered read.
`default_nettype none
module gmti_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

/* src/grid_mesh_triangle_indexer.sv */
// Top level of the grid mesh triangle indexer.
`default_nettype none
// Height samples arrive in raster order, one request per sample; a NaN sample
// is missing. Each sample that closes a grid cell gives up to two triangles
// of linear vertex indices, the last one of a sample flagged by last_of_run.
// A sample is accepted every cycle unless the output stalls or it gives two
// triangles, holding the input until both load: the output register takes one
// triangle per cycle. A RAM read and written at each accepted sample's column
// holds the prior row's valid bits; it needs no reset. Configuration writes
// are always ready; the user makes them while idle, not enforced by the block.
module grid_mesh_triangle_indexer #(
    parameter int MAX_COLUMNS = gmti_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS = gmti_pkg::MAX_ROWS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gmti_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [gmti_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [gmti_pkg::HEIGHT_W-1:0]  i_height_bits,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [gmti_pkg::IDX_W-1:0]     o_vertex_a,
    output logic      [gmti_pkg::IDX_W-1:0]     o_vertex_b,
    output logic      [gmti_pkg::IDX_W-1:0]     o_vertex_c,
    output logic                                o_last_of_run
);
    import gmti_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int LW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int LRW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    typedef struct packed {
        logic             close;
        logic             left;
        logic             cur;
        logic [IDX_W-1:0] ul;
        logic [IDX_W-1:0] ll;
        logic [IDX_W-1:0] lr;
        logic [IDX_W-1:0] ur;
    } t_cell;

    logic [CFG_W-1:0] r_columns;
    logic [CFG_W-1:0] r_rows;
    logic             r_check;

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [IDX_W-1:0] r_idx;
    logic             r_left;
    logic             r_ul_valid;

    logic             r_s1_valid;
    logic             r_phase;
    t_cell            r_s1;
    t_cell            n_s1;

    logic             r_out_valid;
    logic [IDX_W-1:0] r_va;
    logic [IDX_W-1:0] r_vb;
    logic [IDX_W-1:0] r_vc;
    logic             r_last;

    logic [LW-1:0]    w_cols_ext;
    logic [LW-1:0]    w_ncol;
    logic [LRW-1:0]   w_rows_ext;
    logic [LRW-1:0]   w_nrow;
    logic             w_cur;
    logic             w_accept;
    logic             w_above;
    logic             w_col_wrap;
    logic             w_row_wrap;
    logic             w_t1;
    logic             w_t2;
    logic             w_emit;
    logic             w_sel2;
    logic             w_last;
    logic             w_fin;
    logic             w_load_ok;
    logic             w_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= CFG_W'(MIN_SIZE);
            r_rows <= CFG_W'(MIN_SIZE);
            r_check <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_COLUMNS: r_columns <= i_cfg_data;
                REG_ROWS: r_rows <= i_cfg_data;
                REG_CHECK: r_check <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cols_ext = LW'(r_columns);
        priority if (w_cols_ext < LW'(MIN_SIZE)) begin
            w_ncol = LW'(MIN_SIZE);
        end else if (w_cols_ext > LW'(MAX_COLUMNS)) begin
            w_ncol = LW'(MAX_COLUMNS);
        end else begin
            w_ncol = w_cols_ext;
        end
        w_rows_ext = LRW'(r_rows);
        priority if (w_rows_ext < LRW'(MIN_SIZE)) begin
            w_nrow = LRW'(MIN_SIZE);
        end else if (w_rows_ext > LRW'(MAX_ROWS)) begin
            w_nrow = LRW'(MAX_ROWS);
        end else begin
            w_nrow = w_rows_ext;
        end
    end

    assign w_cur = !((i_height_bits[30:23] == EXP_ALL_ONES) &&
                     (i_height_bits[22:0] != MAN_ZERO));
    assign w_col_wrap = (LW'(r_col) + LW'(1)) >= w_ncol;
    assign w_row_wrap = (LRW'(r_row) + LRW'(1)) >= w_nrow;

    always_comb begin
        n_s1.close = (r_row != '0) && (r_col != '0);
        n_s1.left = r_left;
        n_s1.cur = w_cur;
        n_s1.lr = r_idx;
        n_s1.ll = r_idx - IDX_W'(1);
        n_s1.ur = r_idx - IDX_W'(w_ncol);
        n_s1.ul = r_idx - IDX_W'(w_ncol) - IDX_W'(1);
    end

    gmti_ram #(
        .WIDTH(1),
        .DEPTH(MAX_COLUMNS)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (w_accept),
        .i_re   (w_accept),
        .i_addr (r_col),
        .i_wdata(w_cur),
        .o_rdata(w_above)
    );

    assign w_t1 = r_s1.close && (!r_check || (r_ul_valid && r_s1.left && r_s1.cur));
    assign w_t2 = r_s1.close && (!r_check || (r_ul_valid && r_s1.cur && w_above));

    always_comb begin
        if (r_phase) begin
            w_emit = 1'b1;
            w_sel2 = 1'b1;
            w_last = 1'b1;
            w_fin = 1'b1;
        end else begin
            w_emit = w_t1 || w_t2;
            w_sel2 = !w_t1;
            w_last = !(w_t1 && w_t2);
            w_fin = !(w_t1 && w_t2);
        end
    end

    assign w_load_ok = !r_out_valid || !i_out_stall;
    assign w_done = r_s1_valid && (!w_emit || w_load_ok) && w_fin;
    assign o_in_stall = r_s1_valid && !w_done;
    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
            r_left <= 1'b0;
        end else if (w_accept) begin
            r_left <= w_cur;
            if (w_col_wrap) begin
                r_col <= '0;
                if (w_row_wrap) begin
                    r_row <= '0;
                    r_idx <= '0;
                end else begin
                    r_row <= r_row + RW'(1);
                    r_idx <= r_idx + IDX_W'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_phase <= 1'b0;
            r_ul_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_ul_valid <= w_above;
                r_phase <= 1'b0;
            end else if (r_s1_valid && w_emit && w_load_ok) begin
                r_phase <= 1'b1;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_done) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && w_emit && w_load_ok) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_emit && w_load_ok) begin
            r_va <= r_s1.ul;
            r_vb <= w_sel2 ? r_s1.lr : r_s1.ll;
            r_vc <= w_sel2 ? r_s1.ur : r_s1.lr;
            r_last <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_vertex_a = r_va;
    assign o_vertex_b = r_vb;
    assign o_vertex_c = r_vc;
    assign o_last_of_run = r_last;

`ifndef ASSERT_OFF
    a_phase_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> r_s1_valid)
        else $error("Second triangle pending without a sample in flight.");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_of_run) |=> (o_out_valid && o_last_of_run))
        else $error("First triangle of a pair was not followed by the closing one.");

    a_free_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("Input stalled with no sample in flight.");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW'(r_col) < LW'(MAX_COLUMNS)))
        else $error("Column counter beyond the line buffer depth.");
`endif
endmodule
`default_nettype wire
